// File: rtl/smpd_pkg.sv
`default_nettype none
package smpd_pkg;

    localparam int AXES_DEF       = 3;
    localparam int AXES_MAX       = 3;
    localparam int POWER_ITER_DEF = 16;
    localparam int ITER_MAX       = 32;

    localparam logic [31:0] GAIN_POS_LOW_RST  = 32'd327680;
    localparam logic [31:0] GAIN_POS_HIGH_RST = 32'd327680;
    localparam logic [31:0] GAIN_VEL_LOW_RST  = 32'd393216;
    localparam logic [31:0] GAIN_VEL_HIGH_RST = 32'd393216;
    localparam logic [12:0] SMALL_EXP_RST     = 13'd2662;
    localparam logic [13:0] LARGE_EXP_RST     = 14'd4915;
    localparam logic [23:0] STEP_TIME_RST     = 24'd167772;

    localparam logic [30:0] MAG_MAX = '1;

    typedef enum logic [3:0] {
        LN_IDLE,
        LN_NORM,
        LN_LOG,
        LN_EXP_MUL,
        LN_EXP,
        LN_SCALE,
        LN_GAIN,
        LN_VSUM,
        LN_VSTEP,
        LN_PSUM,
        LN_PSTEP,
        LN_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        REG_GAIN_POS_LOW  = 3'd0,
        REG_GAIN_POS_HIGH = 3'd1,
        REG_GAIN_VEL_LOW  = 3'd2,
        REG_GAIN_VEL_HIGH = 3'd3,
        REG_SMALL_EXP     = 3'd4,
        REG_LARGE_EXP     = 3'd5,
        REG_STEP_TIME     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] gain_pos_low;
        logic [31:0] gain_pos_high;
        logic [31:0] gain_vel_low;
        logic [31:0] gain_vel_high;
        logic [12:0] small_exponent;
        logic [13:0] large_exponent;
        logic [23:0] step_time;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] est;
        logic signed [31:0] vel;
        logic signed [31:0] err;
        logic               clip;
    } lane_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

    typedef logic [31:0] root_tab_t [0:ITER_MAX];

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = val;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    function automatic root_tab_t root_table();
        root_tab_t   tab;
        logic [63:0] root;
        root   = 64'd1 << 31;
        tab[0] = root[31:0];
        for (int i = 1; i <= ITER_MAX; i++) begin
            root   = isqrt64(root << 30);
            tab[i] = root[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = root_table();

    // {clip, value}
    function automatic logic [32:0] sat32(input logic signed [49:0] v);
        logic [32:0] r;
        if (v > 50'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -50'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sliding_mode_position_differentiator.sv
`default_nettype none
// Second-order sliding-mode differentiator for a 3-D position in Q16.16. One lane per axis
// runs the error, four signed powers |e|^p (log2 by repeated squaring, exp2 by a product of
// square-root factors) and the velocity and position updates; a merge stage joins the lanes
// into one registered result. The log and exp series each run N = min(POWER_ITER, 32)
// iterations, 16 at the default. A lane whose error is zero skips the log and exp steps and
// goes straight to the gain step. One item is in the lanes at a time; in_ready rises once
// the previous result has moved into the output register and every lane is idle again.
module sliding_mode_position_differentiator #(
    parameter int AXES       = smpd_pkg::AXES_DEF,
    parameter int POWER_ITER = smpd_pkg::POWER_ITER_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] meas_x,
    input  wire logic signed [31:0] meas_y,
    input  wire logic signed [31:0] meas_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      est_x,
    output logic signed [31:0]      est_y,
    output logic signed [31:0]      est_z,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z,
    output logic signed [31:0]      err_x,
    output logic signed [31:0]      err_y,
    output logic signed [31:0]      err_z,
    output logic                    saturated
);
    import smpd_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic signed [31:0] meas_arr [AXES_MAX];
    lane_stat_t         lane_stat [AXES];
    lane_res_t          lane_res [AXES];
    lane_res_t          out_res [AXES_MAX];
    logic               lane_release;
    logic               all_idle;
    logic               start;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_POS_LOW:  cfg_next.gain_pos_low   = cfg_data;
                REG_GAIN_POS_HIGH: cfg_next.gain_pos_high  = cfg_data;
                REG_GAIN_VEL_LOW:  cfg_next.gain_vel_low   = cfg_data;
                REG_GAIN_VEL_HIGH: cfg_next.gain_vel_high  = cfg_data;
                REG_SMALL_EXP:     cfg_next.small_exponent = cfg_data[12:0];
                REG_LARGE_EXP:     cfg_next.large_exponent = cfg_data[13:0];
                REG_STEP_TIME:     cfg_next.step_time      = cfg_data[23:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.gain_pos_low   <= GAIN_POS_LOW_RST;
            cfg_reg.gain_pos_high  <= GAIN_POS_HIGH_RST;
            cfg_reg.gain_vel_low   <= GAIN_VEL_LOW_RST;
            cfg_reg.gain_vel_high  <= GAIN_VEL_HIGH_RST;
            cfg_reg.small_exponent <= SMALL_EXP_RST;
            cfg_reg.large_exponent <= LARGE_EXP_RST;
            cfg_reg.step_time      <= STEP_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign meas_arr[0] = meas_x;
    assign meas_arr[1] = meas_y;
    assign meas_arr[2] = meas_z;

    always_comb
    begin
        all_idle = 1'b1;
        for (int j = 0; j < AXES; j++) begin
            all_idle = all_idle & lane_stat[j].idle;
        end
    end

    assign in_ready = all_idle;
    assign start    = in_valid & in_ready;

    generate
        for (genvar g = 0; g < AXES; g++) begin : g_lane
            smpd_lane #(
                .POWER_ITER (POWER_ITER)
            ) u_lane (
                .clk          (clk),
                .rst_n        (rst_n),
                .start        (start),
                .lane_release (lane_release),
                .meas         (meas_arr[g]),
                .cfg          (cfg_reg),
                .stat         (lane_stat[g]),
                .res          (lane_res[g])
            );
        end
    endgenerate

    smpd_merge #(
        .AXES (AXES)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane_stat    (lane_stat),
        .lane_res     (lane_res),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .lane_release (lane_release),
        .out_res      (out_res),
        .out_sat      (saturated)
    );

    assign est_x = out_res[0].est;
    assign est_y = out_res[1].est;
    assign est_z = out_res[2].est;
    assign vel_x = out_res[0].vel;
    assign vel_y = out_res[1].vel;
    assign vel_z = out_res[2].vel;
    assign err_x = out_res[0].err;
    assign err_y = out_res[1].err;
    assign err_z = out_res[2].err;

endmodule
`default_nettype wire

// File: rtl/smpd_lane.sv
`default_nettype none
module smpd_lane #(
    parameter int POWER_ITER = smpd_pkg::POWER_ITER_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               lane_release,
    input  wire logic signed [31:0] meas,
    input  wire smpd_pkg::cfg_t     cfg,
    output smpd_pkg::lane_stat_t    stat,
    output smpd_pkg::lane_res_t     res
);
    import smpd_pkg::*;

    localparam int IT = (POWER_ITER > ITER_MAX) ? ITER_MAX : POWER_ITER;

    lane_state_t        state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         pidx_reg, pidx_next;
    logic signed [31:0] e_reg, e_next;
    logic               neg_reg, neg_next;
    logic [31:0]        y_reg, y_next;
    logic [4:0]         k_reg, k_next;
    logic [31:0]        frac_reg, frac_next;
    logic [7:0]         ubh_reg, ubh_next;
    logic [31:0]        f32_reg, f32_next;
    logic [30:0]        r_reg, r_next;
    logic [30:0]        pw_reg [4];
    logic [30:0]        pw_next [4];
    logic signed [31:0] term_reg [4];
    logic signed [31:0] term_next [4];
    logic signed [31:0] vd_reg, vd_next;
    logic signed [31:0] pd_reg, pd_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] pos_reg, pos_next;
    logic               flag_reg, flag_next;

    logic [32:0]        e_sat;
    logic [31:0]        e_abs;
    logic [63:0]        sq;
    logic [31:0]        ys;
    logic [5:0]         fbit_idx;
    logic [5:0]         kk;
    logic signed [36:0] lg;
    logic [13:0]        a2;
    logic [14:0]        b2;
    logic [15:0]        p_sel;
    logic signed [53:0] tprod;
    logic signed [53:0] ub;
    logic [62:0]        ex_prod;
    logic signed [8:0]  sc;
    logic signed [8:0]  shamt;
    logic [30:0]        mag_scaled;
    logic [31:0]        gsel;
    logic [62:0]        gprod;
    logic signed [49:0] gsig;
    logic [32:0]        g_sat;
    logic [32:0]        vd_sat;
    logic [32:0]        pd_sat;
    logic               st_neg;
    logic [31:0]        st_abs;
    logic [55:0]        st_prod;
    logic signed [49:0] st_step;
    logic [32:0]        vel_sat;
    logic [32:0]        pos_sat;

    assign e_sat = sat32(50'(meas) - 50'(pos_reg));
    assign e_abs = e_sat[31] ? 32'(-e_sat[31:0]) : e_sat[31:0];

    assign sq       = 64'(y_reg) * 64'(y_reg);
    assign ys       = sq[61:30];
    assign fbit_idx = 6'd32 - cnt_reg;

    assign kk  = 6'({1'b0, k_reg}) - 6'd16;
    assign lg  = $signed({kk[4:0], frac_reg});
    assign a2  = (cfg.small_exponent < 13'd2048) ? 14'd0
                 : 14'({cfg.small_exponent, 1'b0} - 14'd4096);
    assign b2  = (cfg.large_exponent < 14'd2048) ? 15'd0
                 : 15'({cfg.large_exponent, 1'b0} - 15'd4096);

    always_comb
    begin
        case (pidx_reg)
            2'd0:    p_sel = 16'(a2);
            2'd1:    p_sel = 16'(b2);
            2'd2:    p_sel = 16'(cfg.small_exponent);
            default: p_sel = 16'(cfg.large_exponent);
        endcase
    end

    assign tprod = 54'(lg) * 54'($signed({1'b0, p_sel}));
    assign ub    = tprod + (54'sd1 <<< 51);

    assign ex_prod = 63'(r_reg) * 63'(ROOT_TAB[cnt_reg]);

    assign sc    = $signed({1'b0, ubh_reg}) - 9'sd142;
    assign shamt = -sc;

    always_comb
    begin
        if (sc > 9'sd0) begin
            mag_scaled = MAG_MAX;
        end else if (sc == 9'sd0) begin
            mag_scaled = r_reg;
        end else if (shamt >= 9'sd32) begin
            mag_scaled = '0;
        end else begin
            mag_scaled = r_reg >> shamt[4:0];
        end
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    gsel = cfg.gain_vel_low;
            2'd1:    gsel = cfg.gain_vel_high;
            2'd2:    gsel = cfg.gain_pos_low;
            default: gsel = cfg.gain_pos_high;
        endcase
    end

    assign gprod = 63'(pw_reg[cnt_reg[1:0]]) * 63'(gsel);
    assign gsig  = neg_reg ? -$signed({3'b0, gprod[62:16]}) : $signed({3'b0, gprod[62:16]});
    assign g_sat = sat32(gsig);

    assign vd_sat = sat32(50'(term_reg[0]) + 50'(term_reg[1]));
    assign pd_sat = sat32(50'(vel_reg) + 50'(term_reg[2]) + 50'(term_reg[3]));

    assign st_neg  = (state_reg == LN_VSTEP) ? vd_reg[31] : pd_reg[31];
    assign st_abs  = (state_reg == LN_VSTEP) ? (vd_reg[31] ? 32'(-vd_reg) : vd_reg)
                                             : (pd_reg[31] ? 32'(-pd_reg) : pd_reg);
    assign st_prod = 56'(st_abs) * 56'(cfg.step_time);
    assign st_step = st_neg ? -$signed({18'b0, st_prod[55:24]})
                            : $signed({18'b0, st_prod[55:24]});
    assign vel_sat = sat32(50'(vel_reg) + st_step);
    assign pos_sat = sat32(50'(pos_reg) + st_step);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        e_next     = e_reg;
        neg_next   = neg_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        ubh_next   = ubh_reg;
        f32_next   = f32_reg;
        r_next     = r_reg;
        vd_next    = vd_reg;
        pd_next    = pd_reg;
        vel_next   = vel_reg;
        pos_next   = pos_reg;
        flag_next  = flag_reg;
        for (int j = 0; j < 4; j++) begin
            pw_next[j]   = pw_reg[j];
            term_next[j] = term_reg[j];
        end

        case (state_reg)
            LN_IDLE:
            begin
                if (start) begin
                    e_next    = e_sat[31:0];
                    neg_next  = e_sat[31];
                    flag_next = e_sat[32];
                    y_next    = e_abs;
                    k_next    = 5'd31;
                    cnt_next  = '0;
                    pidx_next = '0;
                    for (int j = 0; j < 4; j++) begin
                        pw_next[j] = '0;
                    end
                    state_next = (e_sat[31:0] == 32'd0) ? LN_GAIN : LN_NORM;
                end
            end
            LN_NORM:
            begin
                case (cnt_reg)
                    6'd0:
                    begin
                        if (y_reg[31:16] == 16'd0) begin
                            y_next = y_reg << 16;
                            k_next = k_reg - 5'd16;
                        end
                    end
                    6'd1:
                    begin
                        if (y_reg[31:24] == 8'd0) begin
                            y_next = y_reg << 8;
                            k_next = k_reg - 5'd8;
                        end
                    end
                    6'd2:
                    begin
                        if (y_reg[31:28] == 4'd0) begin
                            y_next = y_reg << 4;
                            k_next = k_reg - 5'd4;
                        end
                    end
                    6'd3:
                    begin
                        if (y_reg[31:30] == 2'd0) begin
                            y_next = y_reg << 2;
                            k_next = k_reg - 5'd2;
                        end
                    end
                    default:
                    begin
                        if (!y_reg[31]) begin
                            y_next = {1'b0, y_reg[30:0]};
                            k_next = k_reg - 5'd1;
                        end else begin
                            y_next = {1'b0, y_reg[31:1]};
                        end
                    end
                endcase
                if (cnt_reg == 6'd4) begin
                    cnt_next   = 6'd1;
                    frac_next  = '0;
                    state_next = LN_LOG;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            LN_LOG:
            begin
                if (ys[31]) begin
                    y_next    = {1'b0, ys[31:1]};
                    frac_next = frac_reg | (32'd1 << fbit_idx[4:0]);
                end else begin
                    y_next = ys;
                end
                if (cnt_reg == 6'(IT)) begin
                    state_next = LN_EXP_MUL;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            LN_EXP_MUL:
            begin
                ubh_next   = ub[51:44];
                f32_next   = ub[43:12];
                r_next     = 31'd1 << 30;
                cnt_next   = 6'd1;
                state_next = LN_EXP;
            end
            LN_EXP:
            begin
                if (f32_reg[fbit_idx[4:0]]) begin
                    r_next = ex_prod[60:30];
                end
                if (cnt_reg == 6'(IT)) begin
                    state_next = LN_SCALE;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            LN_SCALE:
            begin
                pw_next[pidx_reg] = mag_scaled;
                if (sc > 9'sd0) begin
                    flag_next = 1'b1;
                end
                if (pidx_reg == 2'd3) begin
                    cnt_next   = '0;
                    state_next = LN_GAIN;
                end else begin
                    pidx_next  = pidx_reg + 2'd1;
                    state_next = LN_EXP_MUL;
                end
            end
            LN_GAIN:
            begin
                term_next[cnt_reg[1:0]] = g_sat[31:0];
                flag_next               = flag_reg | g_sat[32];
                if (cnt_reg == 6'd3) begin
                    state_next = LN_VSUM;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            LN_VSUM:
            begin
                vd_next    = vd_sat[31:0];
                flag_next  = flag_reg | vd_sat[32];
                state_next = LN_VSTEP;
            end
            LN_VSTEP:
            begin
                vel_next   = vel_sat[31:0];
                flag_next  = flag_reg | vel_sat[32];
                state_next = LN_PSUM;
            end
            LN_PSUM:
            begin
                pd_next    = pd_sat[31:0];
                flag_next  = flag_reg | pd_sat[32];
                state_next = LN_PSTEP;
            end
            LN_PSTEP:
            begin
                pos_next   = pos_sat[31:0];
                flag_next  = flag_reg | pos_sat[32];
                state_next = LN_DONE;
            end
            LN_DONE:
            begin
                if (lane_release) begin
                    state_next = LN_IDLE;
                end
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= LN_IDLE;
            vel_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            vel_reg   <= vel_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        pidx_reg <= pidx_next;
        e_reg    <= e_next;
        neg_reg  <= neg_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        frac_reg <= frac_next;
        ubh_reg  <= ubh_next;
        f32_reg  <= f32_next;
        r_reg    <= r_next;
        vd_reg   <= vd_next;
        pd_reg   <= pd_next;
        flag_reg <= flag_next;
        for (int j = 0; j < 4; j++) begin
            pw_reg[j]   <= pw_next[j];
            term_reg[j] <= term_next[j];
        end
    end

    assign stat.idle = (state_reg == LN_IDLE);
    assign stat.done = (state_reg == LN_DONE);
    assign res.est   = pos_reg;
    assign res.vel   = vel_reg;
    assign res.err   = e_reg;
    assign res.clip  = flag_reg;

endmodule
`default_nettype wire

// File: rtl/smpd_merge.sv
`default_nettype none
module smpd_merge #(
    parameter int AXES = smpd_pkg::AXES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire smpd_pkg::lane_stat_t  lane_stat [AXES],
    input  wire smpd_pkg::lane_res_t   lane_res [AXES],
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic                       lane_release,
    output smpd_pkg::lane_res_t        out_res [smpd_pkg::AXES_MAX],
    output logic                       out_sat
);
    import smpd_pkg::*;

    logic      all_done;
    logic      any_clip;
    logic      load;
    logic      valid_reg, valid_next;
    lane_res_t res_reg [AXES_MAX];
    lane_res_t res_next [AXES_MAX];
    logic      sat_reg, sat_next;

    always_comb
    begin
        all_done = 1'b1;
        any_clip = 1'b0;
        for (int j = 0; j < AXES; j++) begin
            all_done = all_done & lane_stat[j].done;
            any_clip = any_clip | lane_res[j].clip;
        end
    end

    assign load = all_done & (!valid_reg | out_ready);

    generate
        for (genvar g = 0; g < AXES_MAX; g++) begin : g_axis
            if (g < AXES) begin : g_live
                assign res_next[g] = load ? lane_res[g] : res_reg[g];
            end else begin : g_pad
                assign res_next[g] = '0;
            end
        end
    endgenerate

    assign sat_next   = load ? any_clip : sat_reg;
    assign valid_next = load | (valid_reg & !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        for (int j = 0; j < AXES_MAX; j++) begin
            res_reg[j] <= res_next[j];
        end
    end

    assign out_valid    = valid_reg;
    assign lane_release = load;
    assign out_sat      = sat_reg;
    assign out_res      = res_reg;

endmodule
`default_nettype wire
